### rtl/core/cwps_pkg.sv
// ----------------------------------------------------------------------------
// cwps_pkg: shared types, constants and cosine table
// Item formats, phase and weight widths, and the quarter-wave cosine table
// built at elaboration time.
// ----------------------------------------------------------------------------
package cwps_pkg;

  // Sizing
  localparam int MAX_ATOMS      = 4096;
  localparam int COS_TABLE_BITS = 10;
  localparam int PHASE_BITS     = 20;
  localparam int HALF_STEP_W    = 18;
  localparam int POS_W          = 32;
  localparam int WEIGHT_W       = 17;
  localparam int PROD_W         = POS_W + WEIGHT_W;
  localparam int ACC_W          = 64;
  localparam int COORD_W        = 48;
  localparam int COS_ENTRY_W    = 16;
  localparam int COS_ENTRIES    = (1 << COS_TABLE_BITS) + 1;
  localparam int COS_IDX_W      = COS_TABLE_BITS + 1;
  localparam int COS_ROM_BITS   = COS_ENTRIES * COS_ENTRY_W;

  // Constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_SQRT_HALF = 17'sd23170;
  localparam logic [COS_ENTRY_W-1:0] COS_MAX = 16'd32768;
  localparam logic [COS_IDX_W-1:0]   COS_FULL = COS_IDX_W'(1 << COS_TABLE_BITS);

  // Configuration register indexes
  localparam logic REG_HALF_STEP = 1'b0;
  localparam logic REG_ZERO_MODE = 1'b1;

  // Item formats
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_atom;
  } pos_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } coord_item_t;

  // Control into the phase unit
  typedef struct packed {
    logic adv;
    logic accept;
    logic last;
  } phase_ctl_t;

  // Control into each axis lane
  typedef struct packed {
    logic adv;
    logic acc_valid;
    logic acc_last;
  } lane_ctl_t;

  // Build the quarter-wave cosine table: entry k is cos(k*pi/2 / 2^B) in
  // units of 2^-15, from a 13-term Taylor series in Q2.30.
  function automatic logic [COS_ROM_BITS-1:0] build_cos_table();
    logic [COS_ROM_BITS-1:0] tbl;
    logic [63:0]             x;
    logic [63:0]             x2;
    logic [63:0]             term;
    logic signed [63:0]      sum;
    int                      k;
    int                      n;
    tbl = '0;
    for (k = 0; k < COS_ENTRIES; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      for (n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum <= 0) begin
        sum = '0;
      end else begin
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768) begin
          sum = 64'sd32768;
        end
      end
      tbl[k*COS_ENTRY_W +: COS_ENTRY_W] = COS_ENTRY_W'(sum);
    end
    return tbl;
  endfunction

  localparam logic [COS_ROM_BITS-1:0] COS_TABLE = build_cos_table();

endpackage

### rtl/core/cwps_phase.sv
// ----------------------------------------------------------------------------
// cwps_phase: phase accumulator and weight lookup
// Keeps the running phase, reads the quarter-wave table and forms the signed
// weight shared by all three axis lanes, registered in the stage after the
// table read.
// ----------------------------------------------------------------------------
module cwps_phase
  import cwps_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  phase_ctl_t                    ctl,
  input  logic [HALF_STEP_W-1:0]        half_step,
  input  logic                          zero_mode,
  output logic signed [WEIGHT_W-1:0]    weight
);

  logic [PHASE_BITS-1:0]     phase_acc;
  logic [PHASE_BITS-1:0]     phase;
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-1:0] frac;
  logic [COS_IDX_W-1:0]      rom_idx;
  logic [COS_ENTRY_W-1:0]    rom_q;
  logic                      neg_q;
  logic                      zero_q;
  logic signed [WEIGHT_W-1:0] mag;

  // Phase of the current item is an odd multiple of the half step
  assign phase   = phase_acc + PHASE_BITS'(half_step);
  assign quad    = phase[PHASE_BITS-1 -: 2];
  assign frac    = phase[PHASE_BITS-3 -: COS_TABLE_BITS];
  assign rom_idx = quad[0] ? (COS_FULL - COS_IDX_W'(frac)) : COS_IDX_W'(frac);

  // Advance by a full step per item, restart after the last atom
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (ctl.accept) begin
      if (ctl.last) begin
        phase_acc <= '0;
      end else begin
        phase_acc <= phase_acc + PHASE_BITS'({half_step, 1'b0});
      end
    end
  end

  // Table read, quadrant sign and mode for the stage after
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rom_q  <= COS_TABLE[rom_idx*COS_ENTRY_W +: COS_ENTRY_W];
      neg_q  <= quad[1] ^ quad[0];
      zero_q <= zero_mode;
    end
  end

  assign mag = $signed({1'b0, rom_q});

  // Apply sign or the constant weight
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      if (zero_q) begin
        weight <= WEIGHT_SQRT_HALF;
      end else if (neg_q) begin
        weight <= -mag;
      end else begin
        weight <= mag;
      end
    end
  end

endmodule

### rtl/core/cwps_lane.sv
// ----------------------------------------------------------------------------
// cwps_lane: one axis multiply-accumulate lane
// Delays the position to meet its weight, multiplies, accumulates in 64 bits
// and rounds and saturates the finished sum to 48 bits.
// ----------------------------------------------------------------------------
module cwps_lane
  import cwps_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  logic signed [POS_W-1:0]       pos,
  input  logic signed [WEIGHT_W-1:0]    weight,
  output logic signed [COORD_W-1:0]     coord
);

  logic signed [POS_W-1:0]  pos1;
  logic signed [POS_W-1:0]  pos2;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;
  logic [ACC_W-1:0]         fin;
  logic [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-COORD_W:0]   top_bits;

  // Hold the position until its weight is ready
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pos1 <= pos;
      pos2 <= pos1;
      prod <= pos2 * weight;
    end
  end

  assign acc_next = acc + ACC_W'(prod);

  // Accumulate; on the last atom hand the sum on and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.adv && ctl.acc_valid) begin
      if (ctl.acc_last) begin
        acc <= '0;
      end else begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.acc_valid && ctl.acc_last) begin
      fin <= acc_next;
    end
  end

  // Round half up at bit 15 and saturate to the signed output range
  assign rnd      = fin + ACC_W'(1 << 14);
  assign shifted  = $signed(rnd) >>> 15;
  assign top_bits = shifted[ACC_W-1:COORD_W-1];

  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      coord = shifted[COORD_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

endmodule

### rtl/core/cosine_weighted_position_sum.sv
// ----------------------------------------------------------------------------
// cosine_weighted_position_sum: cosine-weighted sum of atom positions
// Streams atom positions, weights item i by cos(pi*p*(2i+1)/(2N)) (or a
// constant sqrt(0.5) in mode zero) and emits the three axis sums on the last
// atom of a chain.
//
// Usage:
//   Input channel item_valid/item_stall/item_data carries one atom per item
//   (x, y, z in Q15.16 and a last-atom mark). The output channel
//   result_valid/result_stall/result_data carries one result per chain, only
//   after an item marked last. Registers half_step (address 0) and zero_mode
//   (address 4) are to be written over the APB port only while no chain is
//   in flight; the block does not enforce this. Throughput: one item per
//   cycle while item_stall is low. The last atom's table read is at the edge
//   that takes it; weight, multiply, accumulate, rounding and the output
//   register follow. The three axes run in parallel lanes sharing one weight.
//   Reset clears the sums, the phase, both registers and all valid flags.
//   When the receiver stalls, a waiting result holds in the output register
//   while atoms keep flowing; item_stall rises only once the next finished
//   sum reaches the final stage, and stays high until the waiting result is
//   taken.
// ----------------------------------------------------------------------------
module cosine_weighted_position_sum
  import cwps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Atom items
  input  logic        item_valid,
  output logic        item_stall,
  input  pos_item_t   item_data,
  // Result items
  output logic        result_valid,
  input  logic        result_stall,
  output coord_item_t result_data,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [HALF_STEP_W-1:0]     half_step;
  logic                       zero_mode;
  logic                       adv;
  logic                       out_adv;
  logic                       accept;
  logic                       cfg_write;
  logic                       s1_valid, s2_valid, s3_valid, s4_valid;
  logic                       s1_last, s2_last, s3_last;
  phase_ctl_t                 phase_ctl;
  lane_ctl_t                  lane_ctl;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [COORD_W-1:0]  coord_x, coord_y, coord_z;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step <= '0;
      zero_mode <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_HALF_STEP: half_step <= pwdata[HALF_STEP_W-1:0];
        REG_ZERO_MODE: zero_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_STEP: prdata = 32'(half_step);
      REG_ZERO_MODE: prdata = 32'(zero_mode);
      default:       prdata = '0;
    endcase
  end

  // Output register loads when free or being drained; the pipeline moves
  // unless a finished sum is waiting for it
  assign out_adv    = !result_valid || !result_stall;
  assign adv        = out_adv || !s4_valid;
  assign item_stall = !adv;
  assign accept     = item_valid && adv;

  // Stage valid and last flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid && s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= item_data.last_atom;
      s2_last <= s1_last;
      s3_last <= s2_last;
    end
  end

  assign phase_ctl = '{adv: adv, accept: accept, last: item_data.last_atom};
  assign lane_ctl  = '{adv: adv, acc_valid: s3_valid, acc_last: s3_last};

  cwps_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .ctl       (phase_ctl),
    .half_step (half_step),
    .zero_mode (zero_mode),
    .weight    (weight)
  );

  cwps_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .pos    (item_data.pos_x),
    .weight (weight),
    .coord  (coord_x)
  );

  cwps_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .pos    (item_data.pos_y),
    .weight (weight),
    .coord  (coord_y)
  );

  cwps_lane u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .pos    (item_data.pos_z),
    .weight (weight),
    .coord  (coord_z)
  );

  // Merge the lane sums into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s4_valid) begin
      result_data <= '{coord_x: coord_x, coord_y: coord_y, coord_z: coord_z};
    end
  end

endmodule
